// ===== design/sdp_pkg.sv =====
package sdp_pkg;

   // field widths
   localparam int COORD_W = 12;
   localparam int FRAC_W = 4;
   localparam int DISP_W = 16;
   localparam int COLOUR_W = 8;
   localparam int BASE_W = 20;
   localparam int FX_W = 16;
   localparam int DEPTH_W = 31;
   localparam int POINT_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // decimation by reciprocal multiply
   localparam int MAX_DECIMATION = 16;
   localparam int DEC_W = 5;
   localparam int DEC_IDX_W = $clog2(MAX_DECIMATION);
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W = COORD_W + RECIP_W;
   localparam int CHK_W = COORD_W + DEC_W;

   // ceil(2^17 / d) for d = 1 .. 16; exact floor for any 12-bit operand
   localparam logic [RECIP_W-1:0] DEC_RECIP [MAX_DECIMATION] = '{
      18'd131072, 18'd65536, 18'd43691, 18'd32768,
      18'd26215,  18'd21846, 18'd18725, 18'd16384,
      18'd14564,  18'd13108, 18'd11916, 18'd10923,
      18'd10083,  18'd9363,  18'd8739,  18'd8192
   };

   // reprojection arithmetic
   localparam int NUMR_W = COORD_W + FRAC_W + 2;   // 16*col - cx, signed
   localparam int MAG_W = NUMR_W - 1;
   localparam int DEN_W = 16;
   localparam int NUM_W = 38;                      // |numerator| < 2^37
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = NUM_W / DIV_STEPS;
   localparam int NUM_LANES = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam logic [POINT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [POINT_W-1:0] SAT_NEG = 32'h8000_0000;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BASELINE_UM = 3'd0,
      REG_FOCAL_X     = 3'd1,
      REG_CENTER_X    = 3'd2,
      REG_CENTER_Y    = 3'd3,
      REG_DISP_OFFSET = 3'd4,
      REG_MIN_DEPTH   = 3'd5,
      REG_MAX_DEPTH   = 3'd6,
      REG_DECIMATION  = 3'd7
   } sdp_reg_type;

   typedef struct packed {
      logic [COORD_W-1:0]       col;
      logic [COORD_W-1:0]       row;
      logic signed [DISP_W-1:0] disparity;
      logic [COLOUR_W-1:0]      blue;
      logic [COLOUR_W-1:0]      green;
      logic [COLOUR_W-1:0]      red;
   } sdp_req_type;

   typedef struct packed {
      logic [COORD_W-1:0]        out_col;
      logic [COORD_W-1:0]        out_row;
      logic                      valid_res;
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic signed [POINT_W-1:0] point_z;
      logic [COLOUR_W-1:0]       out_blue;
      logic [COLOUR_W-1:0]       out_green;
      logic [COLOUR_W-1:0]       out_red;
   } sdp_rsp_type;

   typedef struct packed {
      logic [BASE_W-1:0]        baseline_um;
      logic [FX_W-1:0]          focal_x;
      logic [FX_W-1:0]          center_x;
      logic [FX_W-1:0]          center_y;
      logic signed [DISP_W-1:0] disparity_offset;
      logic [DEPTH_W-1:0]       min_depth_um;
      logic [DEPTH_W-1:0]       max_depth_um;
      logic [DEC_W-1:0]         decimation;
   } sdp_cfg_type;

   // word held in the queue: a kept pixel
   typedef struct packed {
      logic [COORD_W-1:0]       col;
      logic [COORD_W-1:0]       row;
      logic signed [DISP_W-1:0] disparity;
      logic [COLOUR_W-1:0]      blue;
      logic [COLOUR_W-1:0]      green;
      logic [COLOUR_W-1:0]      red;
      logic [COORD_W-1:0]       out_col;
      logic [COORD_W-1:0]       out_row;
   } sdp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sdp_queue_stat_type;

   typedef struct packed {
      logic [COORD_W-1:0]  out_col;
      logic [COORD_W-1:0]  out_row;
      logic [COLOUR_W-1:0] blue;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] red;
      logic                ok;
      logic                neg_x;
      logic                neg_y;
   } sdp_meta_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;   // numerator bits still to come, quotient bits shifted in
      logic [DEN_W-1:0] rem;
   } sdp_lane_type;

endpackage

// ===== design/sdp_front.sv =====
module sdp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  sdp_pkg::sdp_cfg_type        cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sdp_pkg::sdp_req_type        req_data,
   input  sdp_pkg::sdp_queue_stat_type q_stat,
   output logic                        push,
   output sdp_pkg::sdp_item_type       push_data
);

   logic                                 f_adv;
   logic [sdp_pkg::DEC_W-1:0]            dec_eff;
   logic [sdp_pkg::DEC_W-1:0]            dec_m1;
   logic [sdp_pkg::RECIP_W-1:0]          recip;
   logic [sdp_pkg::PROD_W-1:0]           col_prod;
   logic [sdp_pkg::PROD_W-1:0]           row_prod;
   logic [sdp_pkg::CHK_W-1:0]            col_back;
   logic [sdp_pkg::CHK_W-1:0]            row_back;

   logic                                 f1_valid_ff;
   sdp_pkg::sdp_req_type                 f1_req_ff;
   logic [sdp_pkg::COORD_W-1:0]          f1_qcol_ff, f1_qcol_in;
   logic [sdp_pkg::COORD_W-1:0]          f1_qrow_ff, f1_qrow_in;
   logic [sdp_pkg::DEC_W-1:0]            f1_dec_ff;

   logic                                 f2_valid_ff;
   logic                                 f2_keep_ff, f2_keep_in;
   sdp_pkg::sdp_item_type                f2_item_ff, f2_item_in;

   // whole front moves together; it only holds for a kept word facing a full queue
   assign f_adv = !(f2_valid_ff && f2_keep_ff && q_stat.full);
   assign req_ready = f_adv;
   assign push = f2_valid_ff && f2_keep_ff && !q_stat.full;
   assign push_data = f2_item_ff;

   always_comb begin
      if (cfg.decimation == '0) begin
         dec_eff = sdp_pkg::DEC_W'(1);
      end else if (cfg.decimation > sdp_pkg::DEC_W'(sdp_pkg::MAX_DECIMATION)) begin
         dec_eff = sdp_pkg::DEC_W'(sdp_pkg::MAX_DECIMATION);
      end else begin
         dec_eff = cfg.decimation;
      end
      dec_m1 = dec_eff - sdp_pkg::DEC_W'(1);
      recip = sdp_pkg::DEC_RECIP[dec_m1[sdp_pkg::DEC_IDX_W-1:0]];
   end

   assign col_prod = {{(sdp_pkg::PROD_W-sdp_pkg::COORD_W){1'b0}}, req_data.col}
                   * {{(sdp_pkg::PROD_W-sdp_pkg::RECIP_W){1'b0}}, recip};
   assign row_prod = {{(sdp_pkg::PROD_W-sdp_pkg::COORD_W){1'b0}}, req_data.row}
                   * {{(sdp_pkg::PROD_W-sdp_pkg::RECIP_W){1'b0}}, recip};
   assign f1_qcol_in = col_prod[sdp_pkg::RECIP_SHIFT +: sdp_pkg::COORD_W];
   assign f1_qrow_in = row_prod[sdp_pkg::RECIP_SHIFT +: sdp_pkg::COORD_W];

   // multiple of the decimation exactly when quotient * dec gives the coordinate back
   assign col_back = {{sdp_pkg::DEC_W{1'b0}}, f1_qcol_ff}
                   * {{sdp_pkg::COORD_W{1'b0}}, f1_dec_ff};
   assign row_back = {{sdp_pkg::DEC_W{1'b0}}, f1_qrow_ff}
                   * {{sdp_pkg::COORD_W{1'b0}}, f1_dec_ff};

   always_comb begin
      f2_keep_in = (col_back == {{sdp_pkg::DEC_W{1'b0}}, f1_req_ff.col})
                && (row_back == {{sdp_pkg::DEC_W{1'b0}}, f1_req_ff.row});
      f2_item_in.col = f1_req_ff.col;
      f2_item_in.row = f1_req_ff.row;
      f2_item_in.disparity = f1_req_ff.disparity;
      f2_item_in.blue = f1_req_ff.blue;
      f2_item_in.green = f1_req_ff.green;
      f2_item_in.red = f1_req_ff.red;
      f2_item_in.out_col = f1_qcol_ff;
      f2_item_in.out_row = f1_qrow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (f_adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         f1_req_ff <= req_data;
         f1_qcol_ff <= f1_qcol_in;
         f1_qrow_ff <= f1_qrow_in;
         f1_dec_ff <= dec_eff;
         f2_keep_ff <= f2_keep_in;
         f2_item_ff <= f2_item_in;
      end
   end

endmodule

// ===== design/sdp_queue.sv =====
module sdp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sdp_pkg::sdp_item_type       push_data,
   input  logic                        pop,
   output sdp_pkg::sdp_item_type       pop_data,
   output sdp_pkg::sdp_queue_stat_type q_stat
);

   sdp_pkg::sdp_item_type             entry_ff [sdp_pkg::QUEUE_DEPTH];
   logic [sdp_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sdp_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sdp_pkg::QUEUE_AW:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + sdp_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sdp_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10: count_in = count_ff + (sdp_pkg::QUEUE_AW+1)'(1);
         2'b01: count_in = count_ff - (sdp_pkg::QUEUE_AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   assign q_stat.full = (count_ff == (sdp_pkg::QUEUE_AW+1)'(sdp_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/sdp_back.sv =====
module sdp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sdp_pkg::sdp_cfg_type        cfg,
   input  sdp_pkg::sdp_queue_stat_type q_stat,
   input  sdp_pkg::sdp_item_type       pop_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sdp_pkg::sdp_rsp_type        rsp_data
);

   // restoring division, DIV_STEPS quotient bits per stage
   function automatic sdp_pkg::sdp_lane_type div_step(input sdp_pkg::sdp_lane_type cur,
                                                      input logic [sdp_pkg::DEN_W-1:0] den);
      logic [sdp_pkg::DEN_W:0] trial;
      sdp_pkg::sdp_lane_type   nxt;
      nxt = cur;
      for (int i = 0; i < sdp_pkg::DIV_STEPS; i++) begin
         trial = {nxt.rem, nxt.num[sdp_pkg::NUM_W-1]};
         nxt.num = {nxt.num[sdp_pkg::NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial = trial - {1'b0, den};
            nxt.num[0] = 1'b1;
         end
         nxt.rem = trial[sdp_pkg::DEN_W-1:0];
      end
      return nxt;
   endfunction

   // apply sign to a quotient magnitude, saturating to 32 bits
   function automatic logic [sdp_pkg::POINT_W-1:0] sat_mag(input logic [sdp_pkg::NUM_W-1:0] q,
                                                          input logic neg);
      logic over;
      over = (q[sdp_pkg::NUM_W-1:sdp_pkg::POINT_W-1] != '0);
      if (neg) begin
         return over ? sdp_pkg::SAT_NEG : -q[sdp_pkg::POINT_W-1:0];
      end
      return over ? sdp_pkg::SAT_POS : q[sdp_pkg::POINT_W-1:0];
   endfunction

   logic                               adv;

   logic [sdp_pkg::NUMR_W-1:0]         nx, ny, nx_neg, ny_neg;
   logic [sdp_pkg::DISP_W:0]           den_full;
   logic                               disp_pos, den_pos;

   logic                               s1_valid_ff;
   sdp_pkg::sdp_meta_type              s1_meta_ff, s1_meta_in;
   logic [sdp_pkg::MAG_W-1:0]          s1_mag_x_ff, s1_mag_x_in;
   logic [sdp_pkg::MAG_W-1:0]          s1_mag_y_ff, s1_mag_y_in;
   logic [sdp_pkg::DEN_W-1:0]          s1_den_ff, s1_den_in;

   logic                               dv_valid_ff [sdp_pkg::DIV_STAGES+1];
   sdp_pkg::sdp_meta_type              dv_meta_ff  [sdp_pkg::DIV_STAGES+1];
   sdp_pkg::sdp_meta_type              dv_meta_in  [sdp_pkg::DIV_STAGES+1];
   logic [sdp_pkg::DEN_W-1:0]          dv_den_ff   [sdp_pkg::DIV_STAGES+1];
   logic [sdp_pkg::DEN_W-1:0]          dv_den_in   [sdp_pkg::DIV_STAGES+1];
   sdp_pkg::sdp_lane_type dv_lane_ff [sdp_pkg::DIV_STAGES+1][sdp_pkg::NUM_LANES];
   sdp_pkg::sdp_lane_type dv_lane_in [sdp_pkg::DIV_STAGES+1][sdp_pkg::NUM_LANES];

   logic                               sat_valid_ff;
   sdp_pkg::sdp_meta_type              sat_meta_ff;
   logic [sdp_pkg::POINT_W-1:0]        sat_x_ff, sat_x_in;
   logic [sdp_pkg::POINT_W-1:0]        sat_y_ff, sat_y_in;
   logic [sdp_pkg::POINT_W-1:0]        sat_z_ff, sat_z_in;

   logic                               rsp_valid_ff;
   sdp_pkg::sdp_rsp_type               rsp_data_ff, rsp_data_in;
   logic                               depth_ok;

   // one enable for the whole back pipeline, taken from the output register
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // stage 1: offsets, signs, denominator and early validity
   always_comb begin
      nx = {2'b00, pop_data.col, {sdp_pkg::FRAC_W{1'b0}}} - {2'b00, cfg.center_x};
      ny = {2'b00, pop_data.row, {sdp_pkg::FRAC_W{1'b0}}} - {2'b00, cfg.center_y};
      nx_neg = -nx;
      ny_neg = -ny;
      s1_mag_x_in = nx[sdp_pkg::NUMR_W-1] ? nx_neg[sdp_pkg::MAG_W-1:0] : nx[sdp_pkg::MAG_W-1:0];
      s1_mag_y_in = ny[sdp_pkg::NUMR_W-1] ? ny_neg[sdp_pkg::MAG_W-1:0] : ny[sdp_pkg::MAG_W-1:0];
      den_full = {pop_data.disparity[sdp_pkg::DISP_W-1], pop_data.disparity}
               + {cfg.disparity_offset[sdp_pkg::DISP_W-1], cfg.disparity_offset};
      disp_pos = !pop_data.disparity[sdp_pkg::DISP_W-1] && (pop_data.disparity != '0);
      den_pos = !den_full[sdp_pkg::DISP_W] && (den_full != '0);
      s1_den_in = den_full[sdp_pkg::DEN_W-1:0];
      s1_meta_in.out_col = pop_data.out_col;
      s1_meta_in.out_row = pop_data.out_row;
      s1_meta_in.blue = pop_data.blue;
      s1_meta_in.green = pop_data.green;
      s1_meta_in.red = pop_data.red;
      s1_meta_in.ok = disp_pos && den_pos && (cfg.baseline_um != '0) && (cfg.focal_x != '0);
      s1_meta_in.neg_x = nx[sdp_pkg::NUMR_W-1];
      s1_meta_in.neg_y = ny[sdp_pkg::NUMR_W-1];
   end

   // stage 2 (divider entry): numerator magnitudes times baseline; then the divide stages
   always_comb begin
      dv_lane_in[0][sdp_pkg::LANE_X].num =
         {{(sdp_pkg::NUM_W-sdp_pkg::MAG_W){1'b0}}, s1_mag_x_ff}
         * {{(sdp_pkg::NUM_W-sdp_pkg::BASE_W){1'b0}}, cfg.baseline_um};
      dv_lane_in[0][sdp_pkg::LANE_Y].num =
         {{(sdp_pkg::NUM_W-sdp_pkg::MAG_W){1'b0}}, s1_mag_y_ff}
         * {{(sdp_pkg::NUM_W-sdp_pkg::BASE_W){1'b0}}, cfg.baseline_um};
      dv_lane_in[0][sdp_pkg::LANE_Z].num =
         {{(sdp_pkg::NUM_W-sdp_pkg::FX_W){1'b0}}, cfg.focal_x}
         * {{(sdp_pkg::NUM_W-sdp_pkg::BASE_W){1'b0}}, cfg.baseline_um};
      for (int l = 0; l < sdp_pkg::NUM_LANES; l++) begin
         dv_lane_in[0][l].rem = '0;
      end
      dv_den_in[0] = s1_den_ff;
      dv_meta_in[0] = s1_meta_ff;
      for (int k = 1; k <= sdp_pkg::DIV_STAGES; k++) begin
         for (int l = 0; l < sdp_pkg::NUM_LANES; l++) begin
            dv_lane_in[k][l] = div_step(dv_lane_ff[k-1][l], dv_den_ff[k-1]);
         end
         dv_den_in[k] = dv_den_ff[k-1];
         dv_meta_in[k] = dv_meta_ff[k-1];
      end
   end

   // saturation stage
   always_comb begin
      sat_x_in = sat_mag(dv_lane_ff[sdp_pkg::DIV_STAGES][sdp_pkg::LANE_X].num,
                         dv_meta_ff[sdp_pkg::DIV_STAGES].neg_x);
      sat_y_in = sat_mag(dv_lane_ff[sdp_pkg::DIV_STAGES][sdp_pkg::LANE_Y].num,
                         dv_meta_ff[sdp_pkg::DIV_STAGES].neg_y);
      sat_z_in = sat_mag(dv_lane_ff[sdp_pkg::DIV_STAGES][sdp_pkg::LANE_Z].num, 1'b0);
   end

   // output stage: depth window and zeroing of rejected points
   always_comb begin
      depth_ok = !(sat_z_ff < {1'b0, cfg.min_depth_um})
              && !((cfg.max_depth_um != '0) && (sat_z_ff > {1'b0, cfg.max_depth_um}));
      rsp_data_in.out_col = sat_meta_ff.out_col;
      rsp_data_in.out_row = sat_meta_ff.out_row;
      rsp_data_in.valid_res = sat_meta_ff.ok && depth_ok;
      rsp_data_in.point_x = rsp_data_in.valid_res ? sat_x_ff : '0;
      rsp_data_in.point_y = rsp_data_in.valid_res ? sat_y_ff : '0;
      rsp_data_in.point_z = rsp_data_in.valid_res ? sat_z_ff : '0;
      rsp_data_in.out_blue = sat_meta_ff.blue;
      rsp_data_in.out_green = sat_meta_ff.green;
      rsp_data_in.out_red = sat_meta_ff.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int k = 0; k <= sdp_pkg::DIV_STAGES; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         sat_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop;
         dv_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k <= sdp_pkg::DIV_STAGES; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         sat_valid_ff <= dv_valid_ff[sdp_pkg::DIV_STAGES];
         rsp_valid_ff <= sat_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff <= s1_meta_in;
         s1_mag_x_ff <= s1_mag_x_in;
         s1_mag_y_ff <= s1_mag_y_in;
         s1_den_ff <= s1_den_in;
         for (int k = 0; k <= sdp_pkg::DIV_STAGES; k++) begin
            dv_meta_ff[k] <= dv_meta_in[k];
            dv_den_ff[k] <= dv_den_in[k];
            for (int l = 0; l < sdp_pkg::NUM_LANES; l++) begin
               dv_lane_ff[k][l] <= dv_lane_in[k][l];
            end
         end
         sat_meta_ff <= dv_meta_ff[sdp_pkg::DIV_STAGES];
         sat_x_ff <= sat_x_in;
         sat_y_ff <= sat_y_in;
         sat_z_ff <= sat_z_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== design/stereo_disparity_to_point_unit.sv =====
// Path from an accepted req word to rsp_valid: 2 front stages, 1 queue, 2 set-up stages,
//   19 divide stages, saturate, output register. Throughput: one word per cycle while
//   rsp_ready stays high, set by the fully pipelined 2-bit-per-stage divider lanes.
// A stalled rsp side holds the back pipeline; the 4-word queue lets the front run on.
// Reset: synchronous, active high; pipelines and queue empty, configuration takes defaults.
module stereo_disparity_to_point_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sdp_pkg::sdp_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sdp_pkg::sdp_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   sdp_pkg::sdp_cfg_type        cfg_ff, cfg_in;
   sdp_pkg::sdp_queue_stat_type q_stat;
   sdp_pkg::sdp_item_type       q_push_data;
   sdp_pkg::sdp_item_type       q_pop_data;
   logic                        q_push;
   logic                        q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (sdp_pkg::sdp_reg_type'(csr_index))
            sdp_pkg::REG_BASELINE_UM: cfg_in.baseline_um = csr_wdata[sdp_pkg::BASE_W-1:0];
            sdp_pkg::REG_FOCAL_X:     cfg_in.focal_x = csr_wdata[sdp_pkg::FX_W-1:0];
            sdp_pkg::REG_CENTER_X:    cfg_in.center_x = csr_wdata[sdp_pkg::FX_W-1:0];
            sdp_pkg::REG_CENTER_Y:    cfg_in.center_y = csr_wdata[sdp_pkg::FX_W-1:0];
            sdp_pkg::REG_DISP_OFFSET: cfg_in.disparity_offset = csr_wdata[sdp_pkg::DISP_W-1:0];
            sdp_pkg::REG_MIN_DEPTH:   cfg_in.min_depth_um = csr_wdata[sdp_pkg::DEPTH_W-1:0];
            sdp_pkg::REG_MAX_DEPTH:   cfg_in.max_depth_um = csr_wdata[sdp_pkg::DEPTH_W-1:0];
            sdp_pkg::REG_DECIMATION:  cfg_in.decimation = csr_wdata[sdp_pkg::DEC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline_um <= sdp_pkg::BASE_W'(100000);
         cfg_ff.focal_x <= sdp_pkg::FX_W'(8000);
         cfg_ff.center_x <= sdp_pkg::FX_W'(5120);
         cfg_ff.center_y <= sdp_pkg::FX_W'(3840);
         cfg_ff.disparity_offset <= '0;
         cfg_ff.min_depth_um <= '0;
         cfg_ff.max_depth_um <= '0;
         cfg_ff.decimation <= sdp_pkg::DEC_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (q_push_data)
   );

   sdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_stat    (q_stat)
   );

   sdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .pop_data  (q_pop_data),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("word pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("word popped from an empty queue");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |->
         (rsp_data.point_x == '0) && (rsp_data.point_y == '0) && (rsp_data.point_z == '0))
      else $error("rejected point carries non-zero coordinates");

   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.valid_res) |-> !rsp_data.point_z[sdp_pkg::POINT_W-1])
      else $error("accepted point has negative depth");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present straight after reset");

endmodule

// ===== bench/tb_stereo_disparity_to_point_unit.sv =====
module tb_stereo_disparity_to_point_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sdp_pkg::*;

   localparam int IDLE_PERCENT = 26;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES = 10;
   localparam int PIXELS_PER_PHASE = 50;
   localparam int REPORT_LIMIT = 10;

   class point_board;
      sdp_cfg_type settings;
      sdp_rsp_type pending_points[$];
      int unsigned failures;

      static function sdp_cfg_type reset_values();
         sdp_cfg_type s;
         s.baseline_um = 20'd100000;
         s.focal_x = 16'd8000;
         s.center_x = 16'd5120;
         s.center_y = 16'd3840;
         s.disparity_offset = '0;
         s.min_depth_um = '0;
         s.max_depth_um = '0;
         s.decimation = 5'd1;
         return s;
      endfunction

      function new();
         settings = reset_values();
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (sdp_reg_type'(idx))
            REG_BASELINE_UM: settings.baseline_um = value[BASE_W-1:0];
            REG_FOCAL_X:     settings.focal_x = value[FX_W-1:0];
            REG_CENTER_X:    settings.center_x = value[FX_W-1:0];
            REG_CENTER_Y:    settings.center_y = value[FX_W-1:0];
            REG_DISP_OFFSET: settings.disparity_offset = value[DISP_W-1:0];
            REG_MIN_DEPTH:   settings.min_depth_um = value[DEPTH_W-1:0];
            REG_MAX_DEPTH:   settings.max_depth_um = value[DEPTH_W-1:0];
            REG_DECIMATION:  settings.decimation = value[DEC_W-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, anything past the maximum as the maximum
      function int unsigned kept_step();
         if (settings.decimation == 0) return 1;
         if (settings.decimation > MAX_DECIMATION) return MAX_DECIMATION;
         return 32'(settings.decimation);
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // reproject one accepted pixel; dropped pixels leave nothing behind
      function void note_pixel(sdp_req_type p);
         sdp_rsp_type pt;
         int unsigned step;
         int den;
         longint b, x, y, z;
         bit ok;
         step = kept_step();
         if ((p.col % step) != 0 || (p.row % step) != 0) return;
         den = int'(p.disparity) + int'(settings.disparity_offset);
         ok = p.disparity > 0 && settings.baseline_um != 0 && settings.focal_x != 0 && den > 0;
         x = 0;
         y = 0;
         z = 0;
         if (ok) begin
            b = longint'(settings.baseline_um);
            x = clamp32((longint'(p.col) * 16 - longint'(settings.center_x)) * b / den);
            y = clamp32((longint'(p.row) * 16 - longint'(settings.center_y)) * b / den);
            z = clamp32(longint'(settings.focal_x) * b / den);
            if (z < longint'(settings.min_depth_um)) ok = 0;
            if (settings.max_depth_um != 0 && z > longint'(settings.max_depth_um)) ok = 0;
         end
         if (!ok) begin
            x = 0;
            y = 0;
            z = 0;
         end
         pt.out_col = COORD_W'(p.col / step);
         pt.out_row = COORD_W'(p.row / step);
         pt.valid_res = ok;
         pt.point_x = x[POINT_W-1:0];
         pt.point_y = y[POINT_W-1:0];
         pt.point_z = z[POINT_W-1:0];
         pt.out_blue = p.blue;
         pt.out_green = p.green;
         pt.out_red = p.red;
         pending_points.push_back(pt);
      endfunction

      function void check_point(sdp_rsp_type got);
         sdp_rsp_type exp;
         if (pending_points.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result word with nothing pending: %p", $realtime, got);
            return;
         end
         exp = pending_points.pop_front();
         if (got.out_col !== exp.out_col || got.out_row !== exp.out_row
             || got.valid_res !== exp.valid_res || got.point_x !== exp.point_x
             || got.point_y !== exp.point_y || got.point_z !== exp.point_z
             || got.out_blue !== exp.out_blue || got.out_green !== exp.out_green
             || got.out_red !== exp.out_red) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("%0t: point mismatch", $realtime);
               $display("  exp col %0d row %0d ok %0b x %0d y %0d z %0d bgr %0d/%0d/%0d",
                        exp.out_col, exp.out_row, exp.valid_res, exp.point_x, exp.point_y,
                        exp.point_z, exp.out_blue, exp.out_green, exp.out_red);
               $display("  got col %0d row %0d ok %0b x %0d y %0d z %0d bgr %0d/%0d/%0d",
                        got.out_col, got.out_row, got.valid_res, got.point_x, got.point_y,
                        got.point_z, got.out_blue, got.out_green, got.out_red);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sdp_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sdp_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   point_board board = new();
   bit steady_flow = 1'b0;
   bit hold_request = 1'b0;
   int quiet_cycles = 0;

   stereo_disparity_to_point_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // every handshake seen at the edge, plus the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) board.note_pixel(req_data);
         if (rsp_valid && rsp_ready) board.check_point(rsp_data);
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold to fill the block up
   initial begin
      int hold_count;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_count = HOLD_CYCLES;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_pixel(sdp_req_type p);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(sdp_reg_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(sdp_cfg_type s);
      write_csr(REG_BASELINE_UM, CSR_DATA_W'(s.baseline_um));
      write_csr(REG_FOCAL_X, CSR_DATA_W'(s.focal_x));
      write_csr(REG_CENTER_X, CSR_DATA_W'(s.center_x));
      write_csr(REG_CENTER_Y, CSR_DATA_W'(s.center_y));
      write_csr(REG_DISP_OFFSET, CSR_DATA_W'(s.disparity_offset));
      write_csr(REG_MIN_DEPTH, CSR_DATA_W'(s.min_depth_um));
      write_csr(REG_MAX_DEPTH, CSR_DATA_W'(s.max_depth_um));
      write_csr(REG_DECIMATION, CSR_DATA_W'(s.decimation));
      csr_valid <= 1'b0;
   endtask

   // dropped pixels may still be in the front stages when the last point leaves
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic sdp_req_type pixel(int unsigned c, int unsigned r, int d,
                                         int unsigned blu, int unsigned grn,
                                         int unsigned rd);
      sdp_req_type p;
      p.col = COORD_W'(c);
      p.row = COORD_W'(r);
      p.disparity = DISP_W'(d);
      p.blue = COLOUR_W'(blu);
      p.green = COLOUR_W'(grn);
      p.red = COLOUR_W'(rd);
      return p;
   endfunction

   // mostly pixels on the kept grid with sensible disparities
   function automatic sdp_req_type random_pixel(int unsigned step);
      sdp_req_type p;
      int unsigned roll;
      int unsigned gray;
      p.col = COORD_W'($urandom);
      p.row = COORD_W'($urandom);
      if ($urandom_range(99) < 70) begin
         p.col = COORD_W'(step * $urandom_range(0, 4095 / step));
         p.row = COORD_W'(step * $urandom_range(0, 4095 / step));
      end
      roll = $urandom_range(99);
      if (roll < 55) p.disparity = DISP_W'($urandom_range(1, 2000));
      else if (roll < 70) p.disparity = DISP_W'($urandom_range(1, 16));
      else p.disparity = DISP_W'($urandom);
      p.blue = COLOUR_W'($urandom);
      p.green = COLOUR_W'($urandom);
      p.red = COLOUR_W'($urandom);
      if ($urandom_range(99) < 10) begin
         gray = $urandom_range(255);
         p.blue = COLOUR_W'(gray);
         p.green = COLOUR_W'(gray);
         p.red = COLOUR_W'(gray);
      end
      return p;
   endfunction

   function automatic sdp_cfg_type random_settings();
      sdp_cfg_type s;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) s.baseline_um = '0;
      else if (roll < 20) s.baseline_um = {BASE_W{1'b1}};
      else s.baseline_um = BASE_W'($urandom_range(1000, 300000));
      roll = $urandom_range(99);
      if (roll < 8) s.focal_x = '0;
      else if (roll < 16) s.focal_x = {FX_W{1'b1}};
      else s.focal_x = FX_W'($urandom_range(1000, 20000));
      s.center_x = FX_W'($urandom);
      s.center_y = FX_W'($urandom);
      if ($urandom_range(99) < 10) s.disparity_offset = DISP_W'($urandom);
      else s.disparity_offset = DISP_W'(int'($urandom_range(0, 4096)) - 2048);
      if ($urandom_range(99) < 60) s.min_depth_um = '0;
      else s.min_depth_um = DEPTH_W'($urandom_range(0, 3000000));
      if ($urandom_range(99) < 50) s.max_depth_um = '0;
      else s.max_depth_um = DEPTH_W'($urandom_range(1000000, 32'h7FFF_FFFF));
      roll = $urandom_range(99);
      if (roll < 50) s.decimation = 5'd1;
      else if (roll < 80) s.decimation = DEC_W'($urandom_range(2, 4));
      else s.decimation = DEC_W'($urandom_range(0, 31));
      return s;
   endfunction

   initial begin
      sdp_cfg_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes of position, disparity and colour
      send_pixel(pixel(0, 0, 16, 0, 0, 0));
      send_pixel(pixel(4095, 4095, 32767, 255, 255, 255));
      send_pixel(pixel(100, 200, 0, 1, 2, 3));
      send_pixel(pixel(100, 200, -1, 4, 5, 6));
      send_pixel(pixel(4095, 0, -32768, 7, 8, 9));
      send_pixel(pixel(320, 240, 1, 10, 11, 12));
      send_pixel(pixel(321, 239, 800, 8'h5A, 8'h5A, 8'h5A));

      // saturation on all three axes; Z pinned at the top still meets min depth
      wait_idle();
      s = point_board::reset_values();
      s.baseline_um = {BASE_W{1'b1}};
      s.focal_x = {FX_W{1'b1}};
      s.center_x = '0;
      s.center_y = {FX_W{1'b1}};
      s.min_depth_um = {DEPTH_W{1'b1}};
      load_settings(s);
      send_pixel(pixel(4095, 0, 1, 13, 14, 15));
      send_pixel(pixel(0, 4095, 32767, 16, 17, 18));

      wait_idle();
      s = point_board::reset_values();
      s.baseline_um = '0;
      load_settings(s);
      send_pixel(pixel(640, 480, 160, 19, 20, 21));

      wait_idle();
      s = point_board::reset_values();
      s.focal_x = '0;
      load_settings(s);
      send_pixel(pixel(640, 480, 160, 22, 23, 24));

      // denominator pushed to or below zero, then a positive one with disparity negative
      wait_idle();
      s = point_board::reset_values();
      s.disparity_offset = -16'sd32768;
      load_settings(s);
      send_pixel(pixel(10, 20, 32767, 25, 26, 27));
      wait_idle();
      s.disparity_offset = 16'sd32767;
      load_settings(s);
      send_pixel(pixel(10, 20, -1, 28, 29, 30));

      // depth window edges: Z = 8e8 / D
      wait_idle();
      s = point_board::reset_values();
      s.min_depth_um = 31'd1000000;
      s.max_depth_um = 31'd2000000;
      load_settings(s);
      send_pixel(pixel(50, 60, 800, 31, 32, 33));
      send_pixel(pixel(50, 60, 801, 34, 35, 36));
      send_pixel(pixel(50, 60, 400, 37, 38, 39));
      send_pixel(pixel(50, 60, 399, 40, 41, 42));

      wait_idle();
      s = point_board::reset_values();
      s.decimation = 5'd0;
      load_settings(s);
      send_pixel(pixel(3, 5, 300, 43, 44, 45));

      wait_idle();
      s.decimation = 5'd17;
      load_settings(s);
      send_pixel(pixel(16, 32, 300, 46, 47, 48));
      send_pixel(pixel(17, 16, 300, 49, 50, 51));

      wait_idle();
      s.decimation = 5'd3;
      load_settings(s);
      send_pixel(pixel(9, 6, 300, 52, 53, 54));
      send_pixel(pixel(10, 6, 300, 55, 56, 57));

      // every register at its top value
      wait_idle();
      s.baseline_um = {BASE_W{1'b1}};
      s.focal_x = {FX_W{1'b1}};
      s.center_x = {FX_W{1'b1}};
      s.center_y = {FX_W{1'b1}};
      s.disparity_offset = 16'sd32767;
      s.min_depth_um = {DEPTH_W{1'b1}};
      s.max_depth_um = {DEPTH_W{1'b1}};
      s.decimation = {DEC_W{1'b1}};
      load_settings(s);
      send_pixel(pixel(4080, 4080, 1, 58, 59, 60));
      send_pixel(pixel(4095, 4095, 32767, 61, 62, 63));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         s = random_settings();
         // the held phase keeps every pixel so that the block is sure to fill
         if (phase == 5) s.decimation = 5'd1;
         load_settings(s);
         steady_flow = (phase == 2 || phase == 3);
         // long hold on the result side while words keep coming
         if (phase == 5) hold_request = 1'b1;
         for (int n = 0; n < PIXELS_PER_PHASE; n++)
            send_pixel(random_pixel(board.kept_step()));
      end
      steady_flow = 1'b0;

      wait_idle();
      if (board.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/sdp_pkg.sv
design/sdp_front.sv
design/sdp_queue.sv
design/sdp_back.sv
design/stereo_disparity_to_point_unit.sv
bench/tb_stereo_disparity_to_point_unit.sv
